### hw/rtl/cgl_pkg.sv
// ----------------------------------------------------------------------------
// cgl_pkg
// Shared types, codes and constants of the character-map glyph lookup.
// ----------------------------------------------------------------------------
package cgl_pkg;

  localparam int TABLE_BYTES = 65536;
  localparam int TBL_AW      = $clog2(TABLE_BYTES);
  localparam int CALC_W      = 40;  // wide enough for 16 + 12 * (2^32 - 1) + 8

  // register indexes of the configuration port
  localparam logic [1:0] CFG_FORMAT = 2'd0;
  localparam logic [1:0] CFG_LENGTH = 2'd1;
  localparam logic [1:0] CFG_GLYPHS = 2'd2;

  // subtable formats
  localparam logic [3:0] FMT_BYTE    = 4'd0;
  localparam logic [3:0] FMT_SEG     = 4'd4;
  localparam logic [3:0] FMT_TRIM16  = 4'd6;
  localparam logic [3:0] FMT_TRIM32  = 4'd10;
  localparam logic [3:0] FMT_SEQ     = 4'd12;
  localparam logic [3:0] FMT_CONST   = 4'd13;
  localparam logic [3:0] FMT_NONE    = 4'd15;

  // read lengths in bytes
  localparam logic [2:0] LEN_B = 3'd1;
  localparam logic [2:0] LEN_H = 3'd2;
  localparam logic [2:0] LEN_W = 3'd4;

  // fixed header offsets
  localparam logic [7:0] OFS_SEG_COUNT = 8'd6;
  localparam logic [7:0] OFS_T16_FIRST = 8'd6;
  localparam logic [7:0] OFS_T16_COUNT = 8'd8;
  localparam logic [7:0] OFS_T16_ARRAY = 8'd10;
  localparam logic [7:0] OFS_T32_FIRST = 8'd12;
  localparam logic [7:0] OFS_T32_COUNT = 8'd16;
  localparam logic [7:0] OFS_T32_ARRAY = 8'd20;
  localparam logic [7:0] OFS_GRP_COUNT = 8'd12;

  typedef enum logic [3:0] {
    AS_IMM,
    AS_CODE_BYTE,
    AS_SEG_END,
    AS_SEG_START,
    AS_SEG_DELTA,
    AS_SEG_ROFF,
    AS_SEG_GLYPH,
    AS_TRIM,
    AS_GRP_END,
    AS_GRP_FIRST,
    AS_GRP_GLYPH
  } addr_sel_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_SET_SEGS,
    OP_SET_N,
    OP_MID,
    OP_STEP,
    OP_SET_FIRST,
    OP_SET_COUNT,
    OP_SET_DELTA,
    OP_SET_ROFF,
    OP_G_RD,
    OP_G_SEGRD,
    OP_G_SEGDIRECT,
    OP_G_GRP_SEQ,
    OP_G_GRP_CONST
  } dp_op_t;

  typedef struct packed {
    logic       rd_go;
    logic [2:0] rd_len;
    addr_sel_t  addr_sel;
    logic [7:0] imm;
    dp_op_t     op;
    logic       emit;
  } cgl_cmd_t;

  typedef struct packed {
    logic rd_busy;
    logic rd_done;
    logic code_neg;
    logic code_big;
    logic code_lt256;
    logic lo_lt_hi;
    logic lo_lt_n;
    logic code_lt_first;
    logic in_trim;
    logic roff_zero;
    logic out_free;
  } cgl_stat_t;

endpackage

### hw/rtl/cgl_ram.sv
// ----------------------------------------------------------------------------
// cgl_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cgl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

endmodule

### hw/rtl/cgl_datapath.sv
// ----------------------------------------------------------------------------
// cgl_datapath
// Subtable byte store, big-endian word reader, search and glyph registers.
// ----------------------------------------------------------------------------
module cgl_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_accept,
  input  logic                 in_operation,
  input  logic [15:0]          in_byte_address,
  input  logic [7:0]           in_byte_value,
  input  logic signed [31:0]   in_character,
  input  logic [16:0]          table_length,
  input  logic [15:0]          glyph_count,
  input  cgl_pkg::cgl_cmd_t    cmd,
  input  logic                 out_stall,
  output cgl_pkg::cgl_stat_t   stat,
  output logic                 out_valid,
  output logic [15:0]          out_glyph
);
  import cgl_pkg::*;

  // read unit
  logic              rd_busy_r, rd_pend_r, rd_done_r;
  logic [2:0]        rd_cnt_r, rd_len_r;
  logic [CALC_W-1:0] rd_addr_r;
  logic [31:0]       acc_r, rd_data_r;
  logic [7:0]        ram_q;
  logic [TBL_AW-1:0] ram_raddr;
  logic [16:0]       vsize;
  logic              rd_ok;
  logic              rd_last;

  // lookup registers
  logic [31:0] code_r, lo_r, hi_r, n_r, mid_r, first_r, count_r, g_r;
  logic [15:0] delta_r, roff_r;
  logic        out_valid_r;
  logic [15:0] out_glyph_r;

  logic [CALC_W-1:0] addr_calc;
  logic [CALC_W-1:0] lo_x, mid_x, n_x, diff_x, imm_x, roff_x;
  logic [31:0]       diff;

  cgl_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_BYTES)
  ) u_ram (
    .clk       (clk),
    .we        (in_accept && !in_operation),
    .waddr     (in_byte_address[TBL_AW-1:0]),
    .wdata     (in_byte_value),
    .raddr     (ram_raddr),
    .rd_data_r (ram_q)
  );

  assign vsize = (table_length > 17'(TABLE_BYTES)) ? 17'(TABLE_BYTES) : table_length;
  assign rd_ok = ({1'b0, rd_addr_r} + {{(CALC_W-2){1'b0}}, rd_len_r})
                 <= {{(CALC_W-16){1'b0}}, vsize};
  assign rd_last = (rd_cnt_r == rd_len_r) && !rd_pend_r;
  assign ram_raddr = rd_addr_r[TBL_AW-1:0] + {{(TBL_AW-3){1'b0}}, rd_cnt_r};

  assign diff   = code_r - first_r;
  assign lo_x   = {{(CALC_W-32){1'b0}}, lo_r};
  assign mid_x  = {{(CALC_W-32){1'b0}}, mid_r};
  assign n_x    = {{(CALC_W-32){1'b0}}, n_r};
  assign diff_x = {{(CALC_W-32){1'b0}}, diff};
  assign imm_x  = {{(CALC_W-8){1'b0}}, cmd.imm};
  assign roff_x = {{(CALC_W-16){1'b0}}, roff_r};

  always_comb begin
    unique case (cmd.addr_sel)
      AS_IMM:       addr_calc = imm_x;
      AS_CODE_BYTE: addr_calc = CALC_W'(6) + {{(CALC_W-32){1'b0}}, code_r};
      AS_SEG_END:   addr_calc = CALC_W'(14) + (mid_x << 1);
      AS_SEG_START: addr_calc = CALC_W'(16) + (n_x << 1) + (lo_x << 1);
      AS_SEG_DELTA: addr_calc = CALC_W'(16) + (n_x << 2) + (lo_x << 1);
      AS_SEG_ROFF:  addr_calc = CALC_W'(16) + (n_x << 2) + (n_x << 1) + (lo_x << 1);
      AS_SEG_GLYPH: addr_calc = CALC_W'(16) + (n_x << 2) + (n_x << 1) + (lo_x << 1)
                                + roff_x + (diff_x << 1);
      AS_TRIM:      addr_calc = imm_x + (diff_x << 1);
      AS_GRP_END:   addr_calc = CALC_W'(20) + (mid_x << 3) + (mid_x << 2);
      AS_GRP_FIRST: addr_calc = CALC_W'(16) + (lo_x << 3) + (lo_x << 2);
      AS_GRP_GLYPH: addr_calc = CALC_W'(24) + (lo_x << 3) + (lo_x << 2);
      default:      addr_calc = imm_x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_busy_r   <= 1'b0;
      rd_pend_r   <= 1'b0;
      rd_done_r   <= 1'b0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_done_r <= 1'b0;
      if (cmd.rd_go) begin
        rd_busy_r <= 1'b1;
        rd_pend_r <= 1'b0;
        rd_cnt_r  <= '0;
      end else if (rd_busy_r) begin
        rd_pend_r <= (rd_cnt_r != rd_len_r);
        if (rd_cnt_r != rd_len_r) begin
          rd_cnt_r <= rd_cnt_r + 3'd1;
        end
        if (rd_last) begin
          rd_busy_r <= 1'b0;
          rd_done_r <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_go) begin
      rd_len_r  <= cmd.rd_len;
      rd_addr_r <= addr_calc;
      acc_r     <= '0;
    end else if (rd_busy_r) begin
      if (rd_pend_r) begin
        acc_r <= {acc_r[23:0], ram_q};
      end
      if (rd_last) begin
        rd_data_r <= rd_ok ? acc_r : 32'd0;
      end
    end

    case (cmd.op)
      OP_INIT: begin
        code_r <= in_character;
        lo_r   <= '0;
        g_r    <= '0;
      end
      OP_SET_SEGS: begin
        n_r  <= {1'b0, rd_data_r[31:1]};
        hi_r <= {1'b0, rd_data_r[31:1]};
      end
      OP_SET_N: begin
        n_r  <= rd_data_r;
        hi_r <= rd_data_r;
      end
      OP_MID:       mid_r <= lo_r + ((hi_r - lo_r) >> 1);
      OP_STEP: begin
        if (rd_data_r < code_r) begin
          lo_r <= mid_r + 32'd1;
        end else begin
          hi_r <= mid_r;
        end
      end
      OP_SET_FIRST: first_r <= rd_data_r;
      OP_SET_COUNT: count_r <= rd_data_r;
      OP_SET_DELTA: delta_r <= rd_data_r[15:0];
      OP_SET_ROFF:  roff_r  <= rd_data_r[15:0];
      OP_G_RD:      g_r <= rd_data_r;
      OP_G_SEGRD: begin
        g_r <= (rd_data_r != 32'd0) ? {16'd0, rd_data_r[15:0] + delta_r} : 32'd0;
      end
      OP_G_SEGDIRECT: g_r <= {16'd0, code_r[15:0] + delta_r};
      OP_G_GRP_SEQ:   g_r <= rd_data_r + diff;
      OP_G_GRP_CONST: g_r <= rd_data_r;
      default: ;
    endcase

    if (cmd.emit) begin
      out_glyph_r <= (g_r < {16'd0, glyph_count}) ? g_r[15:0] : 16'd0;
    end
  end

  always_comb begin
    stat.rd_busy       = rd_busy_r;
    stat.rd_done       = rd_done_r;
    stat.code_neg      = code_r[31];
    stat.code_big      = (code_r[31:16] != 16'd0);
    stat.code_lt256    = (code_r[31:8] == 24'd0);
    stat.lo_lt_hi      = (lo_r < hi_r);
    stat.lo_lt_n       = (lo_r < n_r);
    stat.code_lt_first = (code_r < first_r);
    stat.in_trim       = !(code_r < first_r) && (diff < count_r);
    stat.roff_zero     = (roff_r == 16'd0);
    stat.out_free      = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_glyph = out_glyph_r;

endmodule

### hw/rtl/cgl_ctrl.sv
// ----------------------------------------------------------------------------
// cgl_ctrl
// Lookup sequencer: walks the format's header, binary search and glyph fetch.
// ----------------------------------------------------------------------------
module cgl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_operation,
  input  logic [3:0]         map_format,
  input  cgl_pkg::cgl_stat_t stat,
  output logic               in_stall,
  output cgl_pkg::cgl_cmd_t  cmd
);
  import cgl_pkg::*;

  typedef enum logic [18:0] {
    ST_IDLE     = 19'h00001,
    ST_DISPATCH = 19'h00002,
    ST_WT_G     = 19'h00004,
    ST_WT_FIRST = 19'h00008,
    ST_WT_COUNT = 19'h00010,
    ST_TRIM_CHK = 19'h00020,
    ST_WT_SEGS  = 19'h00040,
    ST_WT_N     = 19'h00080,
    ST_LOOP     = 19'h00100,
    ST_MID_RD   = 19'h00200,
    ST_WT_END   = 19'h00400,
    ST_WT_START = 19'h00800,
    ST_CHK      = 19'h01000,
    ST_WT_DELTA = 19'h02000,
    ST_WT_ROFF  = 19'h04000,
    ST_ROFF_CHK = 19'h08000,
    ST_WT_G4    = 19'h10000,
    ST_WT_GG    = 19'h20000,
    ST_FINISH   = 19'h40000
  } state_t;

  state_t state_r, state_nxt;
  logic   is_seg, is_t32;

  assign is_seg   = (map_format == FMT_SEG);
  assign is_t32   = (map_format == FMT_TRIM32);
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd.rd_go    = 1'b0;
    cmd.rd_len   = LEN_H;
    cmd.addr_sel = AS_IMM;
    cmd.imm      = '0;
    cmd.op       = OP_NONE;
    cmd.emit     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_operation) begin
          cmd.op    = OP_INIT;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_nxt = ST_FINISH;
        if (!stat.code_neg) begin
          case (map_format) inside
            FMT_BYTE: begin
              if (stat.code_lt256) begin
                cmd.rd_go    = 1'b1;
                cmd.rd_len   = LEN_B;
                cmd.addr_sel = AS_CODE_BYTE;
                state_nxt    = ST_WT_G;
              end
            end
            FMT_SEG: begin
              if (!stat.code_big) begin
                cmd.rd_go = 1'b1;
                cmd.imm   = OFS_SEG_COUNT;
                state_nxt = ST_WT_SEGS;
              end
            end
            FMT_TRIM16: begin
              cmd.rd_go = 1'b1;
              cmd.imm   = OFS_T16_FIRST;
              state_nxt = ST_WT_FIRST;
            end
            FMT_TRIM32: begin
              cmd.rd_go  = 1'b1;
              cmd.rd_len = LEN_W;
              cmd.imm    = OFS_T32_FIRST;
              state_nxt  = ST_WT_FIRST;
            end
            FMT_SEQ, FMT_CONST: begin
              cmd.rd_go  = 1'b1;
              cmd.rd_len = LEN_W;
              cmd.imm    = OFS_GRP_COUNT;
              state_nxt  = ST_WT_N;
            end
            default: ;
          endcase
        end
      end
      ST_WT_G: begin
        if (stat.rd_done) begin
          cmd.op    = OP_G_RD;
          state_nxt = ST_FINISH;
        end
      end
      ST_WT_FIRST: begin
        if (stat.rd_done) begin
          cmd.op     = OP_SET_FIRST;
          cmd.rd_go  = 1'b1;
          cmd.rd_len = is_t32 ? LEN_W : LEN_H;
          cmd.imm    = is_t32 ? OFS_T32_COUNT : OFS_T16_COUNT;
          state_nxt  = ST_WT_COUNT;
        end
      end
      ST_WT_COUNT: begin
        if (stat.rd_done) begin
          cmd.op    = OP_SET_COUNT;
          state_nxt = ST_TRIM_CHK;
        end
      end
      ST_TRIM_CHK: begin
        if (stat.in_trim) begin
          cmd.rd_go    = 1'b1;
          cmd.addr_sel = AS_TRIM;
          cmd.imm      = is_t32 ? OFS_T32_ARRAY : OFS_T16_ARRAY;
          state_nxt    = ST_WT_G;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_WT_SEGS: begin
        if (stat.rd_done) begin
          cmd.op    = OP_SET_SEGS;
          state_nxt = ST_LOOP;
        end
      end
      ST_WT_N: begin
        if (stat.rd_done) begin
          cmd.op    = OP_SET_N;
          state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (stat.lo_lt_hi) begin
          cmd.op    = OP_MID;
          state_nxt = ST_MID_RD;
        end else if (!stat.lo_lt_n) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.rd_go    = 1'b1;
          cmd.rd_len   = is_seg ? LEN_H : LEN_W;
          cmd.addr_sel = is_seg ? AS_SEG_START : AS_GRP_FIRST;
          state_nxt    = ST_WT_START;
        end
      end
      ST_MID_RD: begin
        cmd.rd_go    = 1'b1;
        cmd.rd_len   = is_seg ? LEN_H : LEN_W;
        cmd.addr_sel = is_seg ? AS_SEG_END : AS_GRP_END;
        state_nxt    = ST_WT_END;
      end
      ST_WT_END: begin
        if (stat.rd_done) begin
          cmd.op    = OP_STEP;
          state_nxt = ST_LOOP;
        end
      end
      ST_WT_START: begin
        if (stat.rd_done) begin
          cmd.op    = OP_SET_FIRST;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (stat.code_lt_first) begin
          state_nxt = ST_FINISH;
        end else if (is_seg) begin
          cmd.rd_go    = 1'b1;
          cmd.addr_sel = AS_SEG_DELTA;
          state_nxt    = ST_WT_DELTA;
        end else begin
          cmd.rd_go    = 1'b1;
          cmd.rd_len   = LEN_W;
          cmd.addr_sel = AS_GRP_GLYPH;
          state_nxt    = ST_WT_GG;
        end
      end
      ST_WT_DELTA: begin
        if (stat.rd_done) begin
          cmd.op       = OP_SET_DELTA;
          cmd.rd_go    = 1'b1;
          cmd.addr_sel = AS_SEG_ROFF;
          state_nxt    = ST_WT_ROFF;
        end
      end
      ST_WT_ROFF: begin
        if (stat.rd_done) begin
          cmd.op    = OP_SET_ROFF;
          state_nxt = ST_ROFF_CHK;
        end
      end
      ST_ROFF_CHK: begin
        if (stat.roff_zero) begin
          cmd.op    = OP_G_SEGDIRECT;
          state_nxt = ST_FINISH;
        end else begin
          cmd.rd_go    = 1'b1;
          cmd.addr_sel = AS_SEG_GLYPH;
          state_nxt    = ST_WT_G4;
        end
      end
      ST_WT_G4: begin
        if (stat.rd_done) begin
          cmd.op    = OP_G_SEGRD;
          state_nxt = ST_FINISH;
        end
      end
      ST_WT_GG: begin
        if (stat.rd_done) begin
          cmd.op    = (map_format == FMT_SEQ) ? OP_G_GRP_SEQ : OP_G_GRP_CONST;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/cmap_glyph_lookup_core.sv
// ----------------------------------------------------------------------------
// cmap_glyph_lookup_core
// Character-to-glyph lookup over one character-map subtable in a byte RAM.
// ----------------------------------------------------------------------------
// Load transfers are accepted back to back while no lookup is in progress.
// A lookup holds the input off until its result is registered; each word read
// goes byte by byte through the single byte read port.
// Reset clears the sequencer and the config (format 15, length 0, no glyphs);
// the table RAM is not cleared and must be loaded before use.
module cmap_glyph_lookup_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic [15:0]        in_byte_address,
  input  logic [7:0]         in_byte_value,
  input  logic signed [31:0] in_character,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_glyph,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import cgl_pkg::*;

  logic [3:0]  map_format_r;
  logic [16:0] table_length_r;
  logic [15:0] glyph_count_r;
  logic        in_accept;
  cgl_cmd_t    cmd;
  cgl_stat_t   stat;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_format_r   <= FMT_NONE;
      table_length_r <= '0;
      glyph_count_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FORMAT: map_format_r   <= cfg_wdata[3:0];
        CFG_LENGTH: table_length_r <= cfg_wdata[16:0];
        CFG_GLYPHS: glyph_count_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  cgl_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .map_format   (map_format_r),
    .stat         (stat),
    .in_stall     (in_stall),
    .cmd          (cmd)
  );

  cgl_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_accept       (in_accept),
    .in_operation    (in_operation),
    .in_byte_address (in_byte_address),
    .in_byte_value   (in_byte_value),
    .in_character    (in_character),
    .table_length    (table_length_r),
    .glyph_count     (glyph_count_r),
    .cmd             (cmd),
    .out_stall       (out_stall),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_glyph       (out_glyph)
  );

  // a lookup transfer blocks the input until its result is out
  a_lookup_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_operation) |=> in_stall)
    else $error("input not held after lookup transfer");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result emitted over a pending one");

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_go |-> !stat.rd_busy)
    else $error("word read started while reader busy");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("emitted result not presented");

endmodule
